FILE: sv/lfss_pkg.sv
// Shared types and constants for the line-follower steering sequencer.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package lfss_pkg;

   // Field and register widths
   localparam int SensorW  = 4;
   localparam int SteerW   = 9;
   localparam int SpeedW   = 10;
   localparam int TurnW    = 8;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 10;

   // Speed divider: numerator is base * (limit - |turn|), 20 bits
   localparam int NumW     = 2 * SpeedW;
   localparam int DivSteps = NumW;
   localparam int DivCntW  = $clog2(DivSteps);

   // Register indexes
   localparam logic [CsrIdxW-1:0] CSR_FINE_TURN   = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_BIG_TURN    = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_SPIN_TURN   = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_BASE_SPEED  = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_SPEED_LIMIT = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_SPIN_TICKS  = 3'd5;

   // Register reset values
   localparam logic [TurnW-1:0]  FINE_TURN_RST   = 8'd15;
   localparam logic [TurnW-1:0]  BIG_TURN_RST    = 8'd65;
   localparam logic [TurnW-1:0]  SPIN_TURN_RST   = 8'd80;
   localparam logic [SpeedW-1:0] BASE_SPEED_RST  = 10'd300;
   localparam logic [SpeedW-1:0] SPEED_LIMIT_RST = 10'd400;
   localparam logic [TurnW-1:0]  SPIN_TICKS_RST  = 8'd20;

   // Sensor patterns with a special meaning
   localparam logic [SensorW-1:0] PAT_CROSSING  = 4'b0000;
   localparam logic [SensorW-1:0] PAT_ALL_BLACK = 4'b1111;

   // Figure-eight sequencer phases
   typedef enum logic [2:0] {
      PH_IDLE            = 3'd0,
      PH_FIRST_RIGHT     = 3'd1,
      PH_FIRST_WAIT      = 3'd2,
      PH_FIRST_LEFT      = 3'd3,
      PH_WAIT_LEFT_ANGLE = 3'd4,
      PH_SECOND_LEFT     = 3'd5,
      PH_SECOND_WAIT     = 3'd6,
      PH_SECOND_RIGHT    = 3'd7
   } seq_phase_type;

   // Segment progress codes
   localparam logic [1:0] SEG_NONE  = 2'd0;
   localparam logic [1:0] SEG_FIRST = 2'd1;
   localparam logic [1:0] SEG_BOTH  = 2'd2;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_MUL  = 2'd1,
      ST_DIV  = 2'd2,
      ST_DONE = 2'd3
   } ctrl_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;      // take the sensor item, run the sequencer
      logic mul;       // form the speed numerator
      logic div_step;  // one restoring-division step
      logic out_load;  // move the finished result to the output register
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic div_last;  // current step is the final division step
   } dp_status_type;

endpackage

`default_nettype wire

FILE: sv/lfss_ctrl.sv
// Controller for the steering sequencer: handshake and step sequencing.
// Depends on lfss_pkg; drives lfss_datapath through ctrl_cmd_type.
`default_nettype none

module lfss_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   input  lfss_pkg::dp_status_type status,
   output lfss_pkg::ctrl_cmd_type  cmd
);
   import lfss_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // State and output-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            // output register free, or emptied by a transfer this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Checks
   a_load_then_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_MUL)
      else $error("load not followed by multiply");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && status.div_last) |=> state_ff == ST_DONE)
      else $error("division did not end after last step");

   a_out_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result loaded but not presented");

endmodule

`default_nettype wire

FILE: sv/lfss_datapath.sv
// Datapath: registers, figure-eight sequencer, pattern table, speed divider.
// Depends on lfss_pkg; sequenced by lfss_ctrl.
`default_nettype none

module lfss_datapath (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_write_en,
   input  wire  [lfss_pkg::CsrIdxW-1:0]        csr_index,
   input  wire  [lfss_pkg::CsrDataW-1:0]       csr_write_data,
   input  wire  [lfss_pkg::SensorW-1:0]        req_sensor_bits,
   input  lfss_pkg::ctrl_cmd_type              cmd,
   output lfss_pkg::dp_status_type             status,
   output logic signed [lfss_pkg::SteerW-1:0]  rsp_steer_diff,
   output logic [lfss_pkg::SpeedW-1:0]         rsp_forward_speed,
   output logic                                rsp_stop_request,
   output logic                                rsp_integral_scale_pulse,
   output logic                                rsp_line_seen,
   output logic                                rsp_sequencer_idle
);
   import lfss_pkg::*;

   // Configuration registers
   logic [TurnW-1:0]  fine_turn_ff, big_turn_ff, spin_turn_ff, spin_ticks_ff;
   logic [SpeedW-1:0] base_speed_ff, speed_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fine_turn_ff   <= FINE_TURN_RST;
         big_turn_ff    <= BIG_TURN_RST;
         spin_turn_ff   <= SPIN_TURN_RST;
         base_speed_ff  <= BASE_SPEED_RST;
         speed_limit_ff <= SPEED_LIMIT_RST;
         spin_ticks_ff  <= SPIN_TICKS_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FINE_TURN:   fine_turn_ff   <= csr_write_data[TurnW-1:0];
            CSR_BIG_TURN:    big_turn_ff    <= csr_write_data[TurnW-1:0];
            CSR_SPIN_TURN:   spin_turn_ff   <= csr_write_data[TurnW-1:0];
            CSR_BASE_SPEED:  base_speed_ff  <= csr_write_data[SpeedW-1:0];
            CSR_SPEED_LIMIT: speed_limit_ff <= csr_write_data[SpeedW-1:0];
            CSR_SPIN_TICKS:  spin_ticks_ff  <= csr_write_data[TurnW-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer and steering state
   seq_phase_type            phase_ff, phase_in;
   logic [1:0]               seg_ff, seg_in;
   logic [TurnW-1:0]         timer_ff, timer_in;
   logic signed [SteerW-1:0] held_ff, prev_ff;

   // Per-item results waiting for the divider
   logic signed [SteerW-1:0] steer_ff, steer_in;
   logic [TurnW-1:0]         mag_ff, mag_in;
   logic                     zero_ff, zero_in;
   logic                     stop_ff, stop_in;
   logic                     pulse_ff, pulse_in;
   logic                     line_ff, line_in;
   logic                     idle_ff, idle_in;
   logic signed [SteerW-1:0] turn_sel;

   // Sequencer step and pattern table for one tick
   always_comb begin
      logic                     active;
      logic signed [SteerW-1:0] spin_pos;
      logic signed [SteerW-1:0] spin_val;
      logic signed [SteerW-1:0] abs_turn;
      logic [SensorW-1:0]       s;

      s        = req_sensor_bits;
      phase_in = phase_ff;
      seg_in   = seg_ff;
      timer_in = timer_ff;
      active   = 1'b0;
      pulse_in = 1'b0;
      stop_in  = 1'b0;
      spin_pos = signed'({1'b0, spin_turn_ff});
      spin_val = '0;

      // first segment: right-angle pattern starts a right spin
      if (phase_in == PH_IDLE && seg_in == SEG_NONE && (s == 4'b1000 || s == 4'b1100)) begin
         phase_in = PH_FIRST_RIGHT;
         timer_in = '0;
      end
      if (phase_in == PH_FIRST_RIGHT) begin
         active   = 1'b1;
         spin_val = -spin_pos;
         timer_in = timer_in + 8'd1;
         if (timer_in >= spin_ticks_ff) begin
            timer_in = '0;
            phase_in = PH_FIRST_WAIT;
            pulse_in = 1'b1;
         end
      end else if (phase_in == PH_FIRST_WAIT && s == PAT_CROSSING) begin
         phase_in = PH_FIRST_LEFT;
         timer_in = '0;
      end
      if (phase_in == PH_FIRST_LEFT) begin
         active   = 1'b1;
         spin_val = spin_pos;
         timer_in = timer_in + 8'd1;
         if (timer_in >= spin_ticks_ff) begin
            timer_in = '0;
            phase_in = PH_WAIT_LEFT_ANGLE;
            seg_in   = SEG_FIRST;
            pulse_in = 1'b1;
         end
      end

      // second segment: left-angle pattern starts a left spin
      if (phase_in == PH_WAIT_LEFT_ANGLE && seg_in == SEG_FIRST &&
          (s == 4'b0001 || s == 4'b0011)) begin
         phase_in = PH_SECOND_LEFT;
         timer_in = '0;
      end
      if (phase_in == PH_SECOND_LEFT) begin
         active   = 1'b1;
         spin_val = spin_pos;
         timer_in = timer_in + 8'd1;
         if (timer_in >= spin_ticks_ff) begin
            timer_in = '0;
            phase_in = PH_SECOND_WAIT;
            pulse_in = 1'b1;
         end
      end else if (phase_in == PH_SECOND_WAIT && s == PAT_CROSSING) begin
         phase_in = PH_SECOND_RIGHT;
         timer_in = '0;
      end
      if (phase_in == PH_SECOND_RIGHT) begin
         active   = 1'b1;
         spin_val = -spin_pos;
         timer_in = timer_in + 8'd1;
         if (timer_in >= spin_ticks_ff) begin
            timer_in = '0;
            phase_in = PH_IDLE;
            seg_in   = SEG_BOTH;
            pulse_in = 1'b1;
         end
      end

      // pattern table
      case (s) inside
         4'b0010, 4'b1011: turn_sel = signed'({1'b0, fine_turn_ff});
         4'b0100, 4'b1101: turn_sel = -signed'({1'b0, fine_turn_ff});
         4'b1110:          turn_sel = -signed'({1'b0, big_turn_ff});
         PAT_ALL_BLACK:    turn_sel = held_ff;
         4'b0001, 4'b0011, 4'b0111, 4'b1000, 4'b1010, 4'b1100: turn_sel = prev_ff;
         default:          turn_sel = '0;
      endcase
      if (s == PAT_CROSSING && phase_in == PH_IDLE && !active) stop_in = 1'b1;

      abs_turn = turn_sel[SteerW-1] ? -turn_sel : turn_sel;
      mag_in   = abs_turn[TurnW-1:0];

      // spin overrides steering; speed forced to zero in the listed cases
      steer_in = active ? spin_val : turn_sel;
      zero_in  = active || (s == PAT_CROSSING && phase_in == PH_IDLE) ||
                 ({2'b00, mag_in} >= speed_limit_ff);
      line_in  = (s != PAT_CROSSING) && (s != PAT_ALL_BLACK);
      idle_in  = (phase_in == PH_IDLE);
   end

   // Sequencer state update on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         seg_ff   <= SEG_NONE;
         timer_ff <= '0;
         held_ff  <= '0;
         prev_ff  <= '0;
      end else if (cmd.load) begin
         phase_ff <= phase_in;
         seg_ff   <= seg_in;
         timer_ff <= timer_in;
         prev_ff  <= steer_in;
         if (req_sensor_bits != PAT_ALL_BLACK) held_ff <= turn_sel;
      end
   end

   // Pending result fields
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         steer_ff <= steer_in;
         mag_ff   <= mag_in;
         zero_ff  <= zero_in;
         stop_ff  <= stop_in;
         pulse_ff <= pulse_in;
         line_ff  <= line_in;
         idle_ff  <= idle_in;
      end
   end

   // Speed: restoring division of base*(limit-mag) by limit, one bit a step
   logic [NumW-1:0]    num_ff;
   logic [SpeedW-1:0]  rem_ff;
   logic [DivCntW-1:0] div_cnt_ff;
   logic [SpeedW:0]    rem_sh;
   logic [SpeedW+1:0]  trial;
   logic [SpeedW-1:0]  span;

   assign span   = speed_limit_ff - {2'b00, mag_ff};
   assign rem_sh = {rem_ff, num_ff[NumW-1]};
   assign trial  = {1'b0, rem_sh} - {2'b00, speed_limit_ff};

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         num_ff     <= base_speed_ff * span;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
         if (!trial[SpeedW+1]) begin
            rem_ff <= trial[SpeedW-1:0];
            num_ff <= {num_ff[NumW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[SpeedW-1:0];
            num_ff <= {num_ff[NumW-2:0], 1'b0};
         end
      end
   end

   assign status.div_last = (div_cnt_ff == DivCntW'(DivSteps - 1));

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_steer_diff           <= steer_ff;
         rsp_forward_speed        <= zero_ff ? '0 : num_ff[SpeedW-1:0];
         rsp_stop_request         <= stop_ff;
         rsp_integral_scale_pulse <= pulse_ff;
         rsp_line_seen            <= line_ff;
         rsp_sequencer_idle       <= idle_ff;
      end
   end

   // Checks
   a_done_stays_idle: assert property (@(posedge clock) disable iff (reset)
      seg_ff == SEG_BOTH |-> phase_ff == PH_IDLE)
      else $error("sequencer left idle after both segments");

   a_fresh_timer: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE && seg_ff == SEG_NONE) |-> timer_ff == '0)
      else $error("spin timer nonzero before first spin");

   a_mul_clears_cnt: assert property (@(posedge clock) disable iff (reset)
      cmd.mul |=> div_cnt_ff == '0)
      else $error("division counter not cleared");

endmodule

`default_nettype wire

FILE: sv/line_follower_steering_sequencer.sv
// Top level of the line-follower steering sequencer.
// Depends on lfss_pkg, lfss_ctrl and lfss_datapath.
//
//   channel  handshake              payload
//   req      req_valid/req_ready    req_sensor_bits
//   rsp      rsp_valid/rsp_ready    rsp_steer_diff, rsp_forward_speed, flags
//   csr      csr_write_en           csr_index, csr_write_data
//
// Each tick holds the block until its result is loaded: the transfer cycle runs the sequencer
// and pattern table, then come the speed multiply, the bit-serial divider and the load of the
// output register. The result is offered in the same cycle that the next tick can be taken.
// Reset is synchronous; the control, configuration and sequencer registers return to their defaults.
// A result waiting in the output register does not stop the next tick from
// being taken; only its final load waits for the register to empty.
`default_nettype none

module line_follower_steering_sequencer (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_write_en,
   input  wire  [lfss_pkg::CsrIdxW-1:0]        csr_index,
   input  wire  [lfss_pkg::CsrDataW-1:0]       csr_write_data,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  [lfss_pkg::SensorW-1:0]        req_sensor_bits,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic signed [lfss_pkg::SteerW-1:0]  rsp_steer_diff,
   output logic [lfss_pkg::SpeedW-1:0]         rsp_forward_speed,
   output logic                                rsp_stop_request,
   output logic                                rsp_integral_scale_pulse,
   output logic                                rsp_line_seen,
   output logic                                rsp_sequencer_idle
);
   import lfss_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   lfss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lfss_datapath u_datapath (
      .clock                    (clock),
      .reset                    (reset),
      .csr_write_en             (csr_write_en),
      .csr_index                (csr_index),
      .csr_write_data           (csr_write_data),
      .req_sensor_bits          (req_sensor_bits),
      .cmd                      (cmd),
      .status                   (status),
      .rsp_steer_diff           (rsp_steer_diff),
      .rsp_forward_speed        (rsp_forward_speed),
      .rsp_stop_request         (rsp_stop_request),
      .rsp_integral_scale_pulse (rsp_integral_scale_pulse),
      .rsp_line_seen            (rsp_line_seen),
      .rsp_sequencer_idle       (rsp_sequencer_idle)
   );

endmodule

`default_nettype wire
